// ===== design/kte_pkg.sv =====
// Shared types, constants and the arctangent table for the Keplerian to
// equinoctial converter. No dependencies.
`default_nettype none
package kte_pkg;

	localparam int CORDIC_ITERATIONS = 30;
	localparam int QBITS = 33;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} rot_t;

	typedef struct packed {
		logic signed [47:0] a;
		logic        [31:0] e;
		logic        [31:0] lon;
		logic        [2:0]  neg;
	} cside_t;

	typedef struct packed {
		logic [64:0] rem;
		logic [39:0] dv;
		logic [32:0] q;
		logic        ovf;
		logic        zero_n;
		logic        zero_d;
		logic        nsign;
		logic        neg;
	} div_t;

	typedef struct packed {
		logic signed [47:0] p;
		logic        [31:0] f;
		logic        [31:0] g;
		logic        [31:0] lon;
		logic               flag;
	} post_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21353953;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/kte_if.sv =====
// Valid/ready channels carrying Keplerian input items and equinoctial
// result items. No dependencies.
`default_nettype none
interface kte_in_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] semimajor_m;
	logic        [31:0] eccentricity;
	logic        [31:0] inclination;
	logic        [31:0] ascending_node;
	logic        [31:0] perigee_argument;
	logic        [31:0] anomaly;

	modport source (output valid, semimajor_m, eccentricity, inclination, ascending_node,
		perigee_argument, anomaly, input ready);
	modport sink (input valid, semimajor_m, eccentricity, inclination, ascending_node,
		perigee_argument, anomaly, output ready);
endinterface

interface kte_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] semilatus_m;
	logic signed [31:0] f_term;
	logic signed [31:0] g_term;
	logic signed [31:0] h_term;
	logic signed [31:0] k_term;
	logic        [31:0] true_longitude;
	logic               saturated;

	modport source (output valid, semilatus_m, f_term, g_term, h_term, k_term,
		true_longitude, saturated, input ready);
	modport sink (input valid, semilatus_m, f_term, g_term, h_term, k_term,
		true_longitude, saturated, output ready);
endinterface
`default_nettype wire

// ===== design/keplerian_to_equinoctial.sv =====
// Pipeline: one capture stage, one CORDIC cell per iteration, four
// product/rounding stages, 33 division cells, one output register.
// Throughput: one item per cycle; the whole chain advances together and
// holds only while a result waits at the output.
// Reset: arst_n clears every valid bit at once; payload registers are not reset.
`default_nettype none
module keplerian_to_equinoctial (
	input  wire logic clk,
	input  wire logic arst_n,
	kte_in_if.sink    kep,
	kte_out_if.source eqn
);

	localparam int N  = kte_pkg::CORDIC_ITERATIONS;
	localparam int QB = kte_pkg::QBITS;

	// Whole chain advances unless a finished item is held at the output.
	logic en;
	logic out_vld_q;
	assign en        = !out_vld_q || eqn.ready;
	assign kep.ready = en;

	// Fold an angle into [-pi/2, pi/2]; bit 34 flags the half-turn.
	function automatic logic [34:0] fold(input logic [31:0] ang);
		logic signed [33:0] z;
		logic               ng;
		z  = {{2{ang[31]}}, ang};
		ng = 1'b0;
		if (z > 34'sd1073741824) begin
			z  = z - 34'sd2147483648;
			ng = 1'b1;
		end else if (z < -34'sd1073741824) begin
			z  = z + 34'sd2147483648;
			ng = 1'b1;
		end
		return {ng, z};
	endfunction

	// Saturate to 32 bits; bit 32 flags a clip.
	function automatic logic [32:0] sat32(input logic signed [66:0] v);
		logic [32:0] r;
		if (v > 67'sd2147483647)       r = {1'b1, 32'h7FFF_FFFF};
		else if (v < -67'sd2147483648) r = {1'b1, 32'h8000_0000};
		else                           r = {1'b0, v[31:0]};
		return r;
	endfunction

	// Final rounding/saturation of a quotient; bit 32 flags a clip.
	function automatic logic [32:0] finish(input kte_pkg::div_t s);
		logic [32:0] r;
		logic [32:0] nq;
		nq = -s.q;
		if (s.zero_n)      r = 33'd0;
		else if (s.zero_d) r = {1'b1, s.nsign ? 32'h8000_0000 : 32'h7FFF_FFFF};
		else if (s.ovf)    r = {1'b1, s.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		else if (s.neg)    r = (s.q > 33'h0_8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, nq[31:0]};
		else               r = (s.q > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, s.q[31:0]};
		return r;
	endfunction

	// ---------------- capture: fold the three angles ----------------
	logic [31:0] wo_ang;
	logic [34:0] fo_wo, fo_nd, fo_hi;
	assign wo_ang = kep.perigee_argument + kep.ascending_node;
	assign fo_wo  = fold(wo_ang);
	assign fo_nd  = fold(kep.ascending_node);
	assign fo_hi  = fold({1'b0, kep.inclination[31:1]});

	logic                vld_c [0:N];
	kte_pkg::rot_t [2:0] rot_c [0:N];
	kte_pkg::cside_t     side_c[0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= kep.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_c[0][0] <= '{x: kte_pkg::CORDIC_GAIN, y: 34'sd0, z: fo_wo[33:0]};
			rot_c[0][1] <= '{x: kte_pkg::CORDIC_GAIN, y: 34'sd0, z: fo_nd[33:0]};
			rot_c[0][2] <= '{x: kte_pkg::CORDIC_GAIN, y: 34'sd0, z: fo_hi[33:0]};
			side_c[0]   <= '{a: kep.semimajor_m, e: kep.eccentricity,
				lon: wo_ang + kep.anomaly, neg: {fo_hi[34], fo_nd[34], fo_wo[34]}};
		end
	end

	// ---------------- CORDIC cell row ----------------
	for (genvar j = 0; j < N; j++) begin : g_cordic
		kte_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.idx    (5'(j)),
			.vld_i  (vld_c[j]),
			.rot_i  (rot_c[j]),
			.side_i (side_c[j]),
			.vld_q  (vld_c[j+1]),
			.rot_q  (rot_c[j+1]),
			.side_q (side_c[j+1])
		);
	end

	// ---------------- stage 1: products ----------------
	kte_pkg::cside_t    cs;
	logic signed [33:0] c_wo, s_wo, c_nd, s_nd, c_hi, s_hi;
	assign cs   = side_c[N];
	assign c_wo = cs.neg[0] ? -rot_c[N][0].x : rot_c[N][0].x;
	assign s_wo = cs.neg[0] ? -rot_c[N][0].y : rot_c[N][0].y;
	assign c_nd = cs.neg[1] ? -rot_c[N][1].x : rot_c[N][1].x;
	assign s_nd = cs.neg[1] ? -rot_c[N][1].y : rot_c[N][1].y;
	assign c_hi = cs.neg[2] ? -rot_c[N][2].x : rot_c[N][2].x;
	assign s_hi = cs.neg[2] ? -rot_c[N][2].y : rot_c[N][2].y;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [66:0] fp_s1, gp_s1;
	logic signed [67:0] hn_s1, kn_s1;
	logic        [63:0] e2_s1;
	logic signed [33:0] ch_s1;
	logic signed [47:0] a_s1;
	logic        [31:0] lon_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			fp_s1  <= $signed({1'b0, cs.e}) * c_wo;
			gp_s1  <= $signed({1'b0, cs.e}) * s_wo;
			hn_s1  <= s_hi * c_nd;
			kn_s1  <= s_hi * s_nd;
			e2_s1  <= cs.e * cs.e;
			ch_s1  <= c_hi;
			a_s1   <= cs.a;
			lon_s1 <= cs.lon;
		end
	end

	// ---------------- stage 2: round f, g; form 1-e^2; set up quotients ----------------
	logic signed [66:0] fr, gr;
	logic        [32:0] fs, gs;
	logic        [64:0] e2r;
	logic signed [35:0] dd;
	logic        [35:0] dneg;
	logic        [47:0] aneg;
	logic        [33:0] chneg;
	logic        [33:0] chmag;

	assign fr    = (fp_s1 + 67'sd536870912) >>> 30;
	assign gr    = (gp_s1 + 67'sd536870912) >>> 30;
	assign fs    = sat32(fr);
	assign gs    = sat32(gr);
	assign e2r   = {1'b0, e2_s1} + 65'd536870912;
	assign dd    = 36'sd1073741824 - $signed({1'b0, e2r[64:30]});
	assign dneg  = -dd;
	assign aneg  = -a_s1;
	assign chneg = -ch_s1;
	assign chmag = ch_s1[33] ? chneg : ch_s1;

	function automatic kte_pkg::div_t div_setup(input logic signed [67:0] num,
		input logic signed [33:0] den, input logic [33:0] dmag);
		kte_pkg::div_t r;
		logic [67:0]   nneg;
		logic [63:0]   nmag;
		nneg     = -num;
		nmag     = num[67] ? nneg[63:0] : num[63:0];
		r.rem    = {1'b0, nmag} + {26'b0, dmag, 5'b0};
		r.dv     = {dmag, 6'b0};
		r.q      = '0;
		r.ovf    = 1'b0;
		r.zero_n = (num == 68'sd0);
		r.zero_d = (den == 34'sd0);
		r.nsign  = num[67];
		r.neg    = num[67] ^ den[33];
		return r;
	endfunction

	logic [31:0]   f_s2, g_s2, lon_s2;
	logic          flag_s2;
	logic [47:0]   am_s2;
	logic [34:0]   dm_s2;
	logic          pneg_s2;
	kte_pkg::div_t hd_s2, kd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s2    <= fs[31:0];
			g_s2    <= gs[31:0];
			flag_s2 <= fs[32] | gs[32];
			am_s2   <= a_s1[47] ? aneg : a_s1;
			dm_s2   <= dd[35] ? dneg[34:0] : dd[34:0];
			pneg_s2 <= a_s1[47] ^ dd[35];
			hd_s2   <= div_setup(hn_s1, ch_s1, chmag);
			kd_s2   <= div_setup(kn_s1, ch_s1, chmag);
			lon_s2  <= lon_s1;
		end
	end

	// ---------------- stage 3: partial products of p; quotient range check ----------------
	function automatic kte_pkg::div_t ovf_check(input kte_pkg::div_t s);
		kte_pkg::div_t r;
		r     = s;
		r.ovf = ({8'b0, s.rem[64:33]} >= s.dv);
		return r;
	endfunction

	logic [58:0]   pl_s3, ph_s3;
	logic          pneg_s3, flag_s3;
	logic [31:0]   f_s3, g_s3, lon_s3;
	kte_pkg::div_t hd_s3, kd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3   <= am_s2[23:0] * dm_s2;
			ph_s3   <= am_s2[47:24] * dm_s2;
			pneg_s3 <= pneg_s2;
			flag_s3 <= flag_s2;
			f_s3    <= f_s2;
			g_s3    <= g_s2;
			lon_s3  <= lon_s2;
			hd_s3   <= ovf_check(hd_s2);
			kd_s3   <= ovf_check(kd_s2);
		end
	end

	// ---------------- stage 4: round and saturate p ----------------
	logic [82:0] psum;
	logic [52:0] pmag;
	logic [47:0] pval;
	logic        psat;

	assign psum = {24'b0, pl_s3} + {ph_s3, 24'b0} + 83'd536870912;
	assign pmag = psum[82:30];

	always_comb begin
		if (pneg_s3) begin
			psat = (pmag > 53'h0_8000_0000_0000);
			pval = psat ? 48'h8000_0000_0000 : -pmag[47:0];
		end else begin
			psat = (pmag > 53'h0_7FFF_FFFF_FFFF);
			pval = psat ? 48'h7FFF_FFFF_FFFF : pmag[47:0];
		end
	end

	logic           vld_d [0:QB];
	kte_pkg::div_t  hd_d  [0:QB];
	kte_pkg::div_t  kd_d  [0:QB];
	kte_pkg::post_t side_d[0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			hd_d[0]   <= hd_s3;
			kd_d[0]   <= kd_s3;
			side_d[0] <= '{p: pval, f: f_s3, g: g_s3, lon: lon_s3, flag: flag_s3 | psat};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else if (en) begin
			vld_s1   <= vld_c[N];
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
		end
	end
	assign vld_d[0] = vld_s4;

	// ---------------- division cell row, most significant quotient bit first ----------------
	for (genvar j = 0; j < QB; j++) begin : g_div
		kte_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.bitpos (6'(QB - 1 - j)),
			.vld_i  (vld_d[j]),
			.h_i    (hd_d[j]),
			.k_i    (kd_d[j]),
			.side_i (side_d[j]),
			.vld_q  (vld_d[j+1]),
			.h_q    (hd_d[j+1]),
			.k_q    (kd_d[j+1]),
			.side_q (side_d[j+1])
		);
	end

	// ---------------- output register ----------------
	logic [32:0]    hf, kf;
	kte_pkg::post_t ps;
	assign hf = finish(hd_d[QB]);
	assign kf = finish(kd_d[QB]);
	assign ps = side_d[QB];

	logic signed [47:0] p_q;
	logic signed [31:0] f_q, g_q, h_q, k_q;
	logic        [31:0] lon_q;
	logic               sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q   <= ps.p;
			f_q   <= ps.f;
			g_q   <= ps.g;
			h_q   <= hf[31:0];
			k_q   <= kf[31:0];
			lon_q <= ps.lon;
			sat_q <= ps.flag | hf[32] | kf[32];
		end
	end

	assign eqn.valid          = out_vld_q;
	assign eqn.semilatus_m    = p_q;
	assign eqn.f_term         = f_q;
	assign eqn.g_term         = g_q;
	assign eqn.h_term         = h_q;
	assign eqn.k_term         = k_q;
	assign eqn.true_longitude = lon_q;
	assign eqn.saturated      = sat_q;

endmodule
`default_nettype wire

// ===== design/kte_cordic_cell.sv =====
// One CORDIC micro-rotation for three angles side by side, with a registered
// hand-on to the next cell. Depends on kte_pkg.
`default_nettype none
module kte_cordic_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic [4:0]               idx,
	input  wire logic                     vld_i,
	input  wire kte_pkg::rot_t [2:0]      rot_i,
	input  wire kte_pkg::cside_t          side_i,
	output      logic                     vld_q,
	output      kte_pkg::rot_t [2:0]      rot_q,
	output      kte_pkg::cside_t          side_q
);

	kte_pkg::rot_t [2:0] rot_d;
	logic signed [33:0]  at;

	always_comb begin
		at = $signed({2'b00, kte_pkg::atan_lut(idx)});
		for (int l = 0; l < 3; l++) begin
			if (!rot_i[l].z[33]) begin
				rot_d[l].x = rot_i[l].x - (rot_i[l].y >>> idx);
				rot_d[l].y = rot_i[l].y + (rot_i[l].x >>> idx);
				rot_d[l].z = rot_i[l].z - at;
			end else begin
				rot_d[l].x = rot_i[l].x + (rot_i[l].y >>> idx);
				rot_d[l].y = rot_i[l].y - (rot_i[l].x >>> idx);
				rot_d[l].z = rot_i[l].z + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q  <= rot_d;
			side_q <= side_i;
		end
	end

endmodule
`default_nettype wire

// ===== design/kte_div_cell.sv =====
// One restoring-division step for the h and k quotients, passing the other
// results along. Depends on kte_pkg.
`default_nettype none
module kte_div_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [5:0]      bitpos,
	input  wire logic            vld_i,
	input  wire kte_pkg::div_t   h_i,
	input  wire kte_pkg::div_t   k_i,
	input  wire kte_pkg::post_t  side_i,
	output      logic            vld_q,
	output      kte_pkg::div_t   h_q,
	output      kte_pkg::div_t   k_q,
	output      kte_pkg::post_t  side_q
);

	kte_pkg::div_t h_d, k_d;

	function automatic kte_pkg::div_t step(input kte_pkg::div_t s, input logic [5:0] b);
		logic [72:0] sub;
		kte_pkg::div_t r;
		sub = {33'b0, s.dv} << b;
		r = s;
		if (!s.ovf && ({8'b0, s.rem} >= sub)) begin
			r.rem = s.rem - sub[64:0];
			r.q   = s.q | (33'd1 << b);
		end
		return r;
	endfunction

	assign h_d = step(h_i, bitpos);
	assign k_d = step(k_i, bitpos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_q    <= h_d;
			k_q    <= k_d;
			side_q <= side_i;
		end
	end

endmodule
`default_nettype wire

// ===== design/kte_checker.sv =====
// Port-level checks for keplerian_to_equinoctial, bound to the top level.
// Depends on kte_if (through the bound ports).
`default_nettype none
module kte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [47:0] p,
	input wire logic [31:0] f,
	input wire logic [31:0] g,
	input wire logic [31:0] h,
	input wire logic [31:0] k,
	input wire logic        sat
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_hold_p: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(p) && $stable(h))
		else $error("stalled result item changed");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input item taken while output stalled");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sat |->
		(p == 48'h7FFF_FFFF_FFFF) || (p == 48'h8000_0000_0000) ||
		(f == 32'h7FFF_FFFF) || (f == 32'h8000_0000) ||
		(g == 32'h7FFF_FFFF) || (g == 32'h8000_0000) ||
		(h == 32'h7FFF_FFFF) || (h == 32'h8000_0000) ||
		(k == 32'h7FFF_FFFF) || (k == 32'h8000_0000))
		else $error("saturated flag without a clipped field");

endmodule

bind keplerian_to_equinoctial kte_checker u_kte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (kep.ready),
	.out_valid (eqn.valid),
	.out_ready (eqn.ready),
	.p         (eqn.semilatus_m),
	.f         (eqn.f_term),
	.g         (eqn.g_term),
	.h         (eqn.h_term),
	.k         (eqn.k_term),
	.sat       (eqn.saturated)
);
`default_nettype wire
